### hdl/slpb_pkg.sv
`timescale 1ns / 1ps

package slpb_pkg;

    // fixed field widths
    localparam int LIMIT_W = 11;
    localparam int PRIME_W = 10;

    // limit register reset value and lower clamp
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 11'd1000;
    localparam int LIMIT_FLOOR = 3;

    // control from top level to sieve engine
    typedef struct packed {
        logic start;
        logic ack;
    } t_eng_ctl;

    // status from sieve engine to top level
    typedef struct packed {
        logic idle;
        logic done;
    } t_eng_status;

endpackage

### hdl/slpb_req_if.sv
`timescale 1ns / 1ps

// search request channel
interface slpb_req_if;
    logic valid;
    logic ready;
    logic start_search;

    modport source (output valid, output start_search, input ready);
    modport sink (input valid, input start_search, output ready);
endinterface

### hdl/slpb_res_if.sv
`timescale 1ns / 1ps

// search result channel
interface slpb_res_if;
    logic valid;
    logic ready;
    logic [slpb_pkg::PRIME_W-1:0] largest_prime;

    modport source (output valid, output largest_prime, input ready);
    modport sink (input valid, input largest_prime, output ready);
endinterface

### hdl/slpb_engine.sv
`timescale 1ns / 1ps

module slpb_engine #(
    parameter int MAX_LIMIT = 1024,
    parameter int LW = 11
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  slpb_pkg::t_eng_ctl           i_ctl,
    input  logic [LW-1:0]                i_lim,
    output slpb_pkg::t_eng_status        o_status,
    output logic [slpb_pkg::PRIME_W-1:0] o_prime
);

    localparam int AW = $clog2(MAX_LIMIT);
    localparam int PW = LW + 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_BASE,
        S_TEST,
        S_MARK,
        S_SCAN,
        S_HOLD
    } t_state;

    t_state                       r_state;
    logic                         r_idle;
    logic                         r_done;
    logic [slpb_pkg::PRIME_W-1:0] r_prime;
    logic [LW-1:0]                r_lim;
    logic [PW-1:0]                r_ptr;
    logic [AW-1:0]                r_base;
    logic                         r_pend;
    logic [AW-1:0]                r_pend_addr;

    // composite bitmap
    logic                         r_map [MAX_LIMIT];
    logic                         r_rdata;
    logic                         w_we;
    logic                         w_wdata;
    logic [AW-1:0]                w_waddr;
    logic [AW-1:0]                w_raddr;

    logic [2*AW-1:0]              w_sq;
    logic                         w_sq_over;
    logic                         w_ptr_in;

    // base square against limit, pointer inside sieve range
    assign w_sq      = r_base * r_base;
    assign w_sq_over = {{LW{1'b0}}, w_sq} > {{(2*AW){1'b0}}, r_lim};
    assign w_ptr_in  = r_ptr < {1'b0, r_lim};

    // bitmap port control
    assign w_we    = (r_state == S_CLEAR) || ((r_state == S_MARK) && w_ptr_in);
    assign w_wdata = (r_state == S_MARK);
    assign w_waddr = r_ptr[AW-1:0];
    assign w_raddr = (r_state == S_SCAN) ? r_ptr[AW-1:0] : r_base;

    // bitmap memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        r_rdata <= r_map[w_raddr];
    end

    // search sequencer: clear, mark multiples, scan down
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idle  <= 1'b1;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_lim   <= i_lim;
                        r_ptr   <= '0;
                        r_idle  <= 1'b0;
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (r_ptr[LW-1:0] == r_lim - LW'(1)) begin
                        r_base  <= AW'(2);
                        r_state <= S_BASE;
                    end else begin
                        r_ptr <= r_ptr + PW'(1);
                    end
                end
                S_BASE: begin
                    if (w_sq_over) begin
                        r_ptr   <= {1'b0, r_lim - LW'(1)};
                        r_pend  <= 1'b0;
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (!r_rdata) begin
                        r_ptr   <= PW'({r_base, 1'b0});
                        r_state <= S_MARK;
                    end else begin
                        r_base  <= r_base + AW'(1);
                        r_state <= S_BASE;
                    end
                end
                S_MARK: begin
                    if (w_ptr_in) begin
                        r_ptr <= r_ptr + PW'(r_base);
                    end else begin
                        r_base  <= r_base + AW'(1);
                        r_state <= S_BASE;
                    end
                end
                S_SCAN: begin
                    if (r_pend && (!r_rdata || r_pend_addr == AW'(2))) begin
                        r_prime <= slpb_pkg::PRIME_W'(r_pend_addr);
                        r_done  <= 1'b1;
                        r_state <= S_HOLD;
                    end else begin
                        r_pend      <= 1'b1;
                        r_pend_addr <= r_ptr[AW-1:0];
                        r_ptr       <= r_ptr - PW'(1);
                    end
                end
                S_HOLD: begin
                    if (i_ctl.ack) begin
                        r_done  <= 1'b0;
                        r_idle  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_status.idle = r_idle;
    assign o_status.done = r_done;
    assign o_prime       = r_prime;

    // checks
    a_done_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_idle)
        else $error("engine reports done while idle");

    a_write_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> w_ptr_in)
        else $error("bitmap write beyond the search limit");

    a_scan_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && r_pend) |-> (r_pend_addr >= AW'(2)))
        else $error("scan went below two");

endmodule

### hdl/sieve_largest_prime_below_unit.sv
`timescale 1ns / 1ps

// Largest prime below a limit. Each request beat with start_search set runs a fresh
// sieve of Eratosthenes over 0 .. L-1 in a bitmap memory with one write and one read
// port and returns one result beat with the largest prime below L; a beat with
// start_search clear is taken and gives no result. L is the search_limit register
// clamped to 3 .. MAX_LIMIT and is sampled when the search starts. A search clears the
// map, tests each base up to sqrt(L), marks the multiples of each prime base, and then
// scans down from L-1 to the answer, which is then handed to the output register.
// One search runs at a time; a finished result waits in the output register while the
// next request is accepted.
module sieve_largest_prime_below_unit #(
    parameter int MAX_LIMIT = 1024
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_search_limit_we,
    input  logic [slpb_pkg::LIMIT_W-1:0] i_search_limit,
    slpb_req_if.sink                     i_req,
    slpb_res_if.source                   o_res
);

    localparam int LW = ($clog2(MAX_LIMIT + 1) > slpb_pkg::LIMIT_W) ?
                        $clog2(MAX_LIMIT + 1) : slpb_pkg::LIMIT_W;

    logic [slpb_pkg::LIMIT_W-1:0] r_limit;
    logic                         r_start;
    logic                         r_out_valid;
    logic [slpb_pkg::PRIME_W-1:0] r_out_prime;

    logic [LW-1:0]                w_lim_ext;
    logic [LW-1:0]                w_lim_eff;
    logic                         w_accept;
    logic                         w_load;
    slpb_pkg::t_eng_ctl           w_ctl;
    slpb_pkg::t_eng_status        w_st;
    logic [slpb_pkg::PRIME_W-1:0] w_prime;

    // limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= slpb_pkg::LIMIT_RESET;
        end else if (i_search_limit_we) begin
            r_limit <= i_search_limit;
        end
    end

    // clamp limit to the sieve range
    assign w_lim_ext = LW'(r_limit);
    always_comb begin
        priority if (w_lim_ext > LW'(MAX_LIMIT)) begin
            w_lim_eff = LW'(MAX_LIMIT);
        end else if (w_lim_ext < LW'(slpb_pkg::LIMIT_FLOOR)) begin
            w_lim_eff = LW'(slpb_pkg::LIMIT_FLOOR);
        end else begin
            w_lim_eff = w_lim_ext;
        end
    end

    // request side
    assign i_req.ready = w_st.idle && !r_start;
    assign w_accept    = i_req.valid && i_req.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= w_accept && i_req.start_search;
        end
    end

    // result register
    assign w_load = w_st.done && (!r_out_valid || o_res.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_prime <= w_prime;
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.largest_prime = r_out_prime;

    assign w_ctl.start = r_start;
    assign w_ctl.ack   = w_load;

    slpb_engine #(
        .MAX_LIMIT (MAX_LIMIT),
        .LW        (LW)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_lim    (w_lim_eff),
        .o_status (w_st),
        .o_prime  (w_prime)
    );

    // checks
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> w_st.idle)
        else $error("search started while engine busy");

endmodule
